@@ src/fbpa_pkg.sv @@
package fbpa_pkg;

   localparam int MAX_BLOCKS = 256;
   localparam int IDX_W      = $clog2(MAX_BLOCKS);
   localparam int CNT_W      = IDX_W + 1;
   localparam int SIZE_W     = 32;
   localparam int STATUS_W   = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CNT_W-1:0]  MIN_BLOCKS     = CNT_W'(64);
   localparam logic [CNT_W-1:0]  MAX_COUNT      = CNT_W'(MAX_BLOCKS);
   localparam logic [SIZE_W-1:0] MIN_BLOCK_SIZE = SIZE_W'(4096);

   // second entry from the top after reset
   localparam logic [IDX_W-1:0] RESET_RD_ADDR = IDX_W'(64 - 2);
   localparam logic [IDX_W-1:0] RESET_TOP     = IDX_W'(64 - 1);

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] ST_ALLOCATED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_OVERSIZE  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FREED     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOT_POOL  = 3'd4;
   localparam logic [STATUS_W-1:0] ST_NOT_ALLOC = 3'd5;

   localparam logic [CSR_IDX_W-1:0] REG_BLOCK_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BLOCK_SIZE  = 2'd1;

   typedef struct packed {
      logic              command;
      logic [SIZE_W-1:0] request_size;
      logic [IDX_W-1:0]  block_index;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [IDX_W-1:0]    granted_index;
      logic [CNT_W-1:0]    free_count;
   } rsp_type;

   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      logic [IDX_W-1:0] wr_data;
      logic [IDX_W-1:0] rd_addr;
      logic             rebuild;
   } stk_ctl_type;

endpackage

@@ src/fbpa_stack.sv @@
// Free stack below the top entry. Read data is registered and always holds
// the entry one below the top. Entries never written since the last rebuild
// read as their own index.
module fbpa_stack (
   input  logic                      clock,
   input  logic                      reset,
   input  fbpa_pkg::stk_ctl_type     ctl,
   output logic [fbpa_pkg::IDX_W-1:0] rd_data
);

   logic [fbpa_pkg::IDX_W-1:0]    stack_mem_ff [fbpa_pkg::MAX_BLOCKS];
   logic [fbpa_pkg::MAX_BLOCKS-1:0] valid_ff;
   logic [fbpa_pkg::IDX_W-1:0]    rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         stack_mem_ff[ctl.wr_addr] <= ctl.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.rebuild) begin
         valid_ff <= '0;
      end else if (ctl.wr_en) begin
         valid_ff[ctl.wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      priority if (reset) begin
         rd_data_ff <= fbpa_pkg::RESET_RD_ADDR;
      end else if (ctl.rebuild) begin
         rd_data_ff <= ctl.rd_addr;
      end else if (ctl.wr_en && (ctl.wr_addr == ctl.rd_addr)) begin
         rd_data_ff <= ctl.wr_data;
      end else if (valid_ff[ctl.rd_addr]) begin
         rd_data_ff <= stack_mem_ff[ctl.rd_addr];
      end else begin
         rd_data_ff <= ctl.rd_addr;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/fixed_block_pool_allocator.sv @@
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_stall  command, request_size, block_index
// rsp_      out        rsp_valid / rsp_stall  status, granted_index, free_count
// csr_      in         csr_wr_en              csr_index, csr_wdata (no read-back)
//
// One request per cycle while the result is not stalled: input register, one pass of logic, result register.
// rsp_valid rises once the request has passed from the input register into the result register.
// The top of stack sits in a register; the stack memory read is registered and
// always presents the next entry down, so back-to-back pops need no bubble.
// Reset is synchronous and leaves 64 blocks free; no clearing pass is needed.
// A stalled result holds the result register; one more request is still taken.
module fixed_block_pool_allocator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  fbpa_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output fbpa_pkg::rsp_type                 rsp_data,
   input  logic                              csr_wr_en,
   input  logic [fbpa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [fbpa_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   logic                          in_valid_ff, in_valid_in;
   fbpa_pkg::req_type             in_data_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   fbpa_pkg::rsp_type             rsp_data_ff, rsp_data_in;
   logic [fbpa_pkg::CNT_W-1:0]    count_ff, count_in;
   logic [fbpa_pkg::SIZE_W-1:0]   size_ff, size_in;
   logic [fbpa_pkg::CNT_W-1:0]    depth_ff, depth_in;
   logic [fbpa_pkg::IDX_W-1:0]    top_ff, top_in;
   logic [fbpa_pkg::MAX_BLOCKS-1:0] in_use_ff, in_use_in;

   logic                          advance;
   logic                          req_take;
   logic                          rebuild;
   logic [fbpa_pkg::CNT_W-1:0]    csr_count;
   logic                          do_pop, do_push;
   logic [fbpa_pkg::STATUS_W-1:0] status;
   logic [fbpa_pkg::IDX_W-1:0]    granted;
   logic [fbpa_pkg::CNT_W-1:0]    rd_sum;
   logic [fbpa_pkg::CNT_W-1:0]    wr_sum;
   logic [fbpa_pkg::CNT_W-1:0]    top_sum;
   logic [fbpa_pkg::IDX_W-1:0]    stk_rd;
   fbpa_pkg::stk_ctl_type         stk_ctl;

   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && rsp_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;
   assign rebuild   = csr_wr_en && (csr_index == fbpa_pkg::REG_BLOCK_COUNT);

   always_comb begin
      csr_count = csr_wdata[fbpa_pkg::CNT_W-1:0];
      if (csr_count < fbpa_pkg::MIN_BLOCKS) begin
         csr_count = fbpa_pkg::MIN_BLOCKS;
      end else if (csr_count > fbpa_pkg::MAX_COUNT) begin
         csr_count = fbpa_pkg::MAX_COUNT;
      end
   end

   always_comb begin
      count_in = count_ff;
      size_in  = size_ff;
      if (rebuild) begin
         count_in = csr_count;
      end
      if (csr_wr_en && (csr_index == fbpa_pkg::REG_BLOCK_SIZE)) begin
         size_in = (csr_wdata < fbpa_pkg::MIN_BLOCK_SIZE) ? fbpa_pkg::MIN_BLOCK_SIZE
                                                         : csr_wdata;
      end
   end

   always_comb begin
      do_pop  = 1'b0;
      do_push = 1'b0;
      granted = '0;
      unique case (in_data_ff.command)
         fbpa_pkg::CMD_ALLOC: begin
            priority if (in_data_ff.request_size > size_ff) begin
               status = fbpa_pkg::ST_OVERSIZE;
            end else if (depth_ff == '0) begin
               status = fbpa_pkg::ST_EMPTY;
            end else begin
               status  = fbpa_pkg::ST_ALLOCATED;
               granted = top_ff;
               do_pop  = 1'b1;
            end
         end
         fbpa_pkg::CMD_FREE: begin
            priority if ({1'b0, in_data_ff.block_index} >= count_ff) begin
               status = fbpa_pkg::ST_NOT_POOL;
            end else if (!in_use_ff[in_data_ff.block_index]) begin
               status = fbpa_pkg::ST_NOT_ALLOC;
            end else if (depth_ff >= fbpa_pkg::MAX_COUNT) begin
               status = fbpa_pkg::ST_NOT_ALLOC;
            end else begin
               status  = fbpa_pkg::ST_FREED;
               do_push = 1'b1;
            end
         end
         default: begin
            status = fbpa_pkg::ST_NOT_ALLOC;
         end
      endcase
   end

   always_comb begin
      top_sum   = count_in - fbpa_pkg::CNT_W'(1);
      depth_in  = depth_ff;
      top_in    = top_ff;
      in_use_in = in_use_ff;
      priority if (rebuild) begin
         depth_in  = count_in;
         top_in    = top_sum[fbpa_pkg::IDX_W-1:0];
         in_use_in = '0;
      end else if (advance && do_pop) begin
         depth_in          = depth_ff - fbpa_pkg::CNT_W'(1);
         top_in            = stk_rd;
         in_use_in[top_ff] = 1'b1;
      end else if (advance && do_push) begin
         depth_in                           = depth_ff + fbpa_pkg::CNT_W'(1);
         top_in                             = in_data_ff.block_index;
         in_use_in[in_data_ff.block_index]  = 1'b0;
      end else begin
         depth_in = depth_ff;
      end
   end

   // old top drops into the memory on a push
   assign rd_sum = depth_in - fbpa_pkg::CNT_W'(2);
   assign wr_sum = depth_ff - fbpa_pkg::CNT_W'(1);

   always_comb begin
      stk_ctl.wr_en   = advance && do_push && (depth_ff != '0) && !rebuild;
      stk_ctl.wr_addr = wr_sum[fbpa_pkg::IDX_W-1:0];
      stk_ctl.wr_data = top_ff;
      stk_ctl.rd_addr = rd_sum[fbpa_pkg::IDX_W-1:0];
      stk_ctl.rebuild = rebuild;
   end

   fbpa_stack u_stack (
      .clock   (clock),
      .reset   (reset),
      .ctl     (stk_ctl),
      .rd_data (stk_rd)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.status        = status;
         rsp_data_in.granted_index = granted;
         rsp_data_in.free_count    = depth_in;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= fbpa_pkg::MIN_BLOCKS;
         size_ff      <= fbpa_pkg::MIN_BLOCK_SIZE;
         depth_ff     <= fbpa_pkg::MIN_BLOCKS;
         top_ff       <= fbpa_pkg::RESET_TOP;
         in_use_ff    <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         size_ff      <= size_in;
         depth_ff     <= depth_in;
         top_ff       <= top_in;
         in_use_ff    <= in_use_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ src/fbpa_checker.sv @@
module fbpa_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input fbpa_pkg::rsp_type rsp_data,
   input logic              csr_wr_en
);

   logic rsp_xfer;

   assign rsp_xfer = rsp_valid && !rsp_stall;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // stall toward requests only while a result is stuck
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without output backpressure");

   a_grant_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != fbpa_pkg::ST_ALLOCATED)
      |-> rsp_data.granted_index == '0)
      else $error("granted index set on a non-grant result");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.free_count <= fbpa_pkg::MAX_COUNT)
      else $error("free count out of range");

   // back-to-back grants each take exactly one block
   a_grant_step: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && $past(rsp_xfer) && !$past(reset) && !$past(csr_wr_en)
      && (rsp_data.status == fbpa_pkg::ST_ALLOCATED)
      |-> rsp_data.free_count == $past(rsp_data.free_count) - fbpa_pkg::CNT_W'(1))
      else $error("grant did not reduce free count by one");

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data),
   .csr_wr_en (csr_wr_en)
);
